// File: hdl/vtal_pkg.sv
// Shared types, constants and fixed-point helpers for the vertex transform
// and lighting block. No dependencies.
package vtal_pkg;

	localparam int COEF_W        = 16;
	localparam int DATA_W        = 24;
	localparam int INT_W         = 16;
	localparam int REG_W         = 64;
	localparam int SHIN_W        = 8;
	localparam int ADDR_W        = 6;
	localparam int COEF_FRAC_DEF = 12;
	localparam int DATA_FRAC_DEF = 16;
	localparam logic [SHIN_W-1:0] SHIN_RESET = 8'd128;

	localparam logic signed [63:0] DATA_MAX64 = (64'sd1 <<< (DATA_W - 1)) - 64'sd1;
	localparam logic signed [63:0] DATA_MIN64 = -(64'sd1 <<< (DATA_W - 1));
	localparam logic signed [63:0] INT_MAX64  = (64'sd1 <<< INT_W) - 64'sd1;

	typedef enum logic [2:0] {
		REG_MVP0    = 3'd0,
		REG_MVP1    = 3'd1,
		REG_MVP2    = 3'd2,
		REG_MVP3    = 3'd3,
		REG_NRM0_KA = 3'd4,
		REG_NRM1_KD = 3'd5,
		REG_NRM2_KS = 3'd6,
		REG_SHIN    = 3'd7
	} reg_idx_t;

	typedef logic signed [COEF_W-1:0] coef_t;
	typedef logic signed [DATA_W-1:0] data_t;

	typedef struct packed {
		logic [3:0][REG_W-1:0] mvp;
		logic [2:0][REG_W-1:0] nrm;
		logic [SHIN_W-1:0]     shin;
	} cfg_t;

	typedef struct packed {
		data_t [3:0] clip;
		data_t       tex_u;
		data_t       tex_v;
	} pass_t;

	function automatic coef_t coef_of(logic [REG_W-1:0] r, int c);
		return coef_t'(r[COEF_W*c +: COEF_W]);
	endfunction

	function automatic logic signed [63:0] rnd_shift(logic signed [63:0] x, int s);
		return (x + (64'sd1 <<< (s - 1))) >>> s;
	endfunction

	function automatic data_t sat_data(logic signed [63:0] x);
		logic signed [63:0] y;
		y = (x > DATA_MAX64) ? DATA_MAX64 : ((x < DATA_MIN64) ? DATA_MIN64 : x);
		return data_t'(y[DATA_W-1:0]);
	endfunction

endpackage

// File: hdl/vtal_cfg.sv
// Configuration registers behind the APB-style port.
// Depends on vtal_pkg.
module vtal_cfg (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [vtal_pkg::ADDR_W-1:0]  paddr,
	input  logic [vtal_pkg::REG_W-1:0]   pwdata,
	output logic [vtal_pkg::REG_W-1:0]   prdata,
	output logic                         pready,
	output vtal_pkg::cfg_t               cfg
);
	import vtal_pkg::*;

	logic [3:0][REG_W-1:0] mvp_q;
	logic [2:0][REG_W-1:0] nrm_q;
	logic [SHIN_W-1:0]     shin_q;
	reg_idx_t              idx;

	assign idx    = reg_idx_t'(paddr[ADDR_W-1:3]);
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mvp_q  <= '0;
			nrm_q  <= '0;
			shin_q <= SHIN_RESET;
		end else if (psel && penable && pwrite) begin
			case (idx)
				REG_MVP0:    mvp_q[0] <= pwdata;
				REG_MVP1:    mvp_q[1] <= pwdata;
				REG_MVP2:    mvp_q[2] <= pwdata;
				REG_MVP3:    mvp_q[3] <= pwdata;
				REG_NRM0_KA: nrm_q[0] <= pwdata;
				REG_NRM1_KD: nrm_q[1] <= pwdata;
				REG_NRM2_KS: nrm_q[2] <= pwdata;
				REG_SHIN:    shin_q   <= pwdata[SHIN_W-1:0];
				default:     shin_q   <= shin_q;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_MVP0:    prdata = mvp_q[0];
			REG_MVP1:    prdata = mvp_q[1];
			REG_MVP2:    prdata = mvp_q[2];
			REG_MVP3:    prdata = mvp_q[3];
			REG_NRM0_KA: prdata = nrm_q[0];
			REG_NRM1_KD: prdata = nrm_q[1];
			REG_NRM2_KS: prdata = nrm_q[2];
			REG_SHIN:    prdata = REG_W'(shin_q);
			default:     prdata = '0;
		endcase
	end

	assign cfg.mvp  = mvp_q;
	assign cfg.nrm  = nrm_q;
	assign cfg.shin = shin_q;

endmodule

// File: hdl/vtal_geom.sv
// Geometry stages 1-4: offset add, matrix products, row sums, rescale and clamp.
// Depends on vtal_pkg.
module vtal_geom #(
	parameter int COEF_FRAC_BITS = vtal_pkg::COEF_FRAC_DEF,
	parameter int DATA_FRAC_BITS = vtal_pkg::DATA_FRAC_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            valid_in,
	input  vtal_pkg::data_t pos_x,
	input  vtal_pkg::data_t pos_y,
	input  vtal_pkg::data_t pos_z,
	input  vtal_pkg::data_t inst_x,
	input  vtal_pkg::data_t inst_y,
	input  vtal_pkg::data_t inst_z,
	input  vtal_pkg::data_t norm_x,
	input  vtal_pkg::data_t norm_y,
	input  vtal_pkg::data_t norm_z,
	input  vtal_pkg::data_t tex_u_in,
	input  vtal_pkg::data_t tex_v_in,
	input  vtal_pkg::cfg_t  cfg,
	output logic            valid_s4,
	output vtal_pkg::pass_t pass_s4,
	output vtal_pkg::data_t ny_s4,
	output vtal_pkg::data_t nz_s4
);
	import vtal_pkg::*;

	localparam int V_W   = DATA_W + 1;
	localparam int MP_W  = COEF_W + V_W;
	localparam int NP_W  = COEF_W + DATA_W;
	localparam int ACC_W = MP_W + 2;
	localparam int NAC_W = NP_W + 2;

	logic                    valid_s1, valid_s2, valid_s3;
	logic signed [V_W-1:0]   v_s1 [3];
	data_t                   n_s1 [3];
	data_t                   tu_s1, tv_s1, tu_s2, tv_s2, tu_s3, tv_s3;
	logic signed [MP_W-1:0]  mp_s2 [4][3];
	logic signed [NP_W-1:0]  np_s2 [2][3];
	logic signed [ACC_W-1:0] acc_s3 [4];
	logic signed [NAC_W-1:0] nac_s3 [2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s1 <= valid_in;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		v_s1[0] <= V_W'(pos_x) + V_W'(inst_x);
		v_s1[1] <= V_W'(pos_y) + V_W'(inst_y);
		v_s1[2] <= V_W'(pos_z) + V_W'(inst_z);
		n_s1[0] <= norm_x;
		n_s1[1] <= norm_y;
		n_s1[2] <= norm_z;
		tu_s1   <= tex_u_in;
		tv_s1   <= tex_v_in;

		for (int r = 0; r < 4; r++) begin
			for (int c = 0; c < 3; c++) begin
				mp_s2[r][c] <= coef_of(cfg.mvp[r], c) * v_s1[c];
			end
		end
		for (int k = 0; k < 2; k++) begin
			for (int c = 0; c < 3; c++) begin
				np_s2[k][c] <= coef_of(cfg.nrm[k+1], c) * n_s1[c];
			end
		end
		tu_s2 <= tu_s1;
		tv_s2 <= tv_s1;

		for (int r = 0; r < 4; r++) begin
			acc_s3[r] <= ACC_W'(mp_s2[r][0]) + ACC_W'(mp_s2[r][1]) + ACC_W'(mp_s2[r][2])
				+ (ACC_W'(coef_of(cfg.mvp[r], 3)) <<< DATA_FRAC_BITS);
		end
		for (int k = 0; k < 2; k++) begin
			nac_s3[k] <= NAC_W'(np_s2[k][0]) + NAC_W'(np_s2[k][1]) + NAC_W'(np_s2[k][2]);
		end
		tu_s3 <= tu_s2;
		tv_s3 <= tv_s2;

		for (int r = 0; r < 4; r++) begin
			pass_s4.clip[r] <= sat_data(rnd_shift(64'(acc_s3[r]), COEF_FRAC_BITS));
		end
		ny_s4         <= sat_data(rnd_shift(64'(nac_s3[0]), COEF_FRAC_BITS));
		nz_s4         <= sat_data(rnd_shift(64'(nac_s3[1]), COEF_FRAC_BITS));
		pass_s4.tex_u <= tu_s3;
		pass_s4.tex_v <= tv_s3;
	end

endmodule

// File: hdl/vtal_light.sv
// Lighting stages 5-16: diffuse and specular terms, unrolled power ladder,
// final sum and clamp. Depends on vtal_pkg.
module vtal_light #(
	parameter int DATA_FRAC_BITS = vtal_pkg::DATA_FRAC_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       valid_in,
	input  vtal_pkg::pass_t            pass_in,
	input  vtal_pkg::data_t            ny,
	input  vtal_pkg::data_t            nz,
	input  vtal_pkg::cfg_t             cfg,
	output logic                       valid_s16,
	output vtal_pkg::pass_t            pass_s16,
	output logic [vtal_pkg::INT_W-1:0] intensity_s16
);
	import vtal_pkg::*;

	localparam int U_W   = DATA_W - 1;
	localparam int P_W   = 2 * U_W;
	localparam int T_W   = DATA_W + 3;
	localparam int KP_W  = COEF_W + DATA_W;
	localparam int NPOW  = SHIN_W;

	function automatic logic [U_W-1:0] umul(logic [U_W-1:0] a, logic [U_W-1:0] b);
		logic [P_W-1:0] p;
		logic [P_W:0]   r;
		p = a * b;
		r = ({1'b0, p} + ((P_W+1)'(1) << (DATA_FRAC_BITS - 1))) >> DATA_FRAC_BITS;
		return (r > (P_W+1)'(DATA_MAX64)) ? U_W'(DATA_MAX64) : r[U_W-1:0];
	endfunction

	logic                          valid_s5, valid_s6, valid_s15;
	logic                          pos_s5, pos_s6, pos_s15;
	pass_t                         pass_s5, pass_s6, pass_s15;
	logic signed [2*DATA_W-1:0]    pnz_s5;
	logic signed [KP_W-1:0]        pkd_s5;
	logic [U_W-1:0]                spec_s6;
	logic signed [T_W-1:0]         tot_s6, tot_s15;
	logic                          pwr_valid_s [1:NPOW];
	logic                          pwr_pos_s   [1:NPOW];
	pass_t                         pwr_pass_s  [1:NPOW];
	logic signed [T_W-1:0]         pwr_tot_s   [1:NPOW];
	logic [U_W-1:0]                pwr_pw_s    [1:NPOW];
	logic [U_W-1:0]                pwr_base_s  [1:NPOW];
	logic signed [KP_W-1:0]        pks_s15;
	logic signed [63:0]            sp_r, tot_f;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5  <= 1'b0;
			valid_s6  <= 1'b0;
			valid_s15 <= 1'b0;
			valid_s16 <= 1'b0;
			for (int k = 1; k <= NPOW; k++) begin
				pwr_valid_s[k] <= 1'b0;
			end
		end else begin
			valid_s5       <= valid_in;
			valid_s6       <= valid_s5;
			pwr_valid_s[1] <= valid_s6;
			for (int k = 2; k <= NPOW; k++) begin
				pwr_valid_s[k] <= pwr_valid_s[k-1];
			end
			valid_s15 <= pwr_valid_s[NPOW];
			valid_s16 <= valid_s15;
		end
	end

	always_comb begin
		sp_r  = rnd_shift(64'(pnz_s5), DATA_FRAC_BITS) <<< 1;
		tot_f = 64'(tot_s15) + (pos_s15 ? rnd_shift(64'(pks_s15), DATA_FRAC_BITS) : 64'sd0);
	end

	always_ff @(posedge clk) begin
		pnz_s5  <= ny * nz;
		pkd_s5  <= coef_of(cfg.nrm[1], 3) * ((ny > 0) ? ny : data_t'(0));
		pos_s5  <= ny > 0;
		pass_s5 <= pass_in;

		spec_s6 <= (sp_r < 0) ? U_W'(0)
			: ((sp_r > DATA_MAX64) ? U_W'(DATA_MAX64) : sp_r[U_W-1:0]);
		tot_s6  <= T_W'(coef_of(cfg.nrm[0], 3))
			+ T_W'(rnd_shift(64'(pkd_s5), DATA_FRAC_BITS));
		pos_s6  <= pos_s5;
		pass_s6 <= pass_s5;

		pwr_pw_s[1]   <= cfg.shin[0] ? umul(U_W'(64'sd1 <<< DATA_FRAC_BITS), spec_s6)
			: U_W'(64'sd1 <<< DATA_FRAC_BITS);
		pwr_base_s[1] <= umul(spec_s6, spec_s6);
		pwr_tot_s[1]  <= tot_s6;
		pwr_pos_s[1]  <= pos_s6;
		pwr_pass_s[1] <= pass_s6;
		for (int k = 2; k <= NPOW; k++) begin
			pwr_pw_s[k]   <= cfg.shin[k-1] ? umul(pwr_pw_s[k-1], pwr_base_s[k-1])
				: pwr_pw_s[k-1];
			pwr_base_s[k] <= umul(pwr_base_s[k-1], pwr_base_s[k-1]);
			pwr_tot_s[k]  <= pwr_tot_s[k-1];
			pwr_pos_s[k]  <= pwr_pos_s[k-1];
			pwr_pass_s[k] <= pwr_pass_s[k-1];
		end

		pks_s15  <= coef_of(cfg.nrm[2], 3) * $signed({1'b0, pwr_pw_s[NPOW]});
		tot_s15  <= pwr_tot_s[NPOW];
		pos_s15  <= pwr_pos_s[NPOW];
		pass_s15 <= pwr_pass_s[NPOW];

		intensity_s16 <= (tot_f < 0) ? INT_W'(0)
			: ((tot_f > INT_MAX64) ? INT_W'(INT_MAX64) : tot_f[INT_W-1:0]);
		pass_s16      <= pass_s15;
	end

endmodule

// File: hdl/vertex_transform_ads_lighting.sv
// Per-vertex transform and ambient/diffuse/specular lighting, top level.
// Depends on vtal_pkg, vtal_cfg, vtal_geom, vtal_light.
//
// Usage:
//   Vertex channel: drive the fields and raise start; a transfer happens at
//   each rising edge with start high and busy low. busy is tied low, so one
//   vertex can enter every cycle.
//   Result channel: done is high for exactly one cycle with clip, texture
//   and intensity fields valid; the receiver must take it then and cannot
//   stall the block.
//   Pipeline: the start edge leads to the done cycle through the
//   4 geometry stages, 2 lighting setup stages, 8 power ladder stages (one
//   exponent bit each) and 2 final stages. Throughput: 1 vertex per cycle.
//   Configuration: 64-bit APB-style registers at byte address 8*index;
//   write only while no vertex is in flight. pready is always high.
//   Reset: clears all valid bits and the registers (shininess to 128);
//   vertices in flight are dropped.
module vertex_transform_ads_lighting #(
	parameter int COEF_FRAC_BITS = vtal_pkg::COEF_FRAC_DEF,
	parameter int DATA_FRAC_BITS = vtal_pkg::DATA_FRAC_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [vtal_pkg::ADDR_W-1:0] paddr,
	input  logic [vtal_pkg::REG_W-1:0]  pwdata,
	output logic [vtal_pkg::REG_W-1:0]  prdata,
	output logic                        pready,
	input  logic                        start,
	output logic                        busy,
	input  vtal_pkg::data_t             pos_x,
	input  vtal_pkg::data_t             pos_y,
	input  vtal_pkg::data_t             pos_z,
	input  vtal_pkg::data_t             inst_x,
	input  vtal_pkg::data_t             inst_y,
	input  vtal_pkg::data_t             inst_z,
	input  vtal_pkg::data_t             norm_x,
	input  vtal_pkg::data_t             norm_y,
	input  vtal_pkg::data_t             norm_z,
	input  vtal_pkg::data_t             tex_u_in,
	input  vtal_pkg::data_t             tex_v_in,
	output logic                        done,
	output vtal_pkg::data_t             clip_x,
	output vtal_pkg::data_t             clip_y,
	output vtal_pkg::data_t             clip_z,
	output vtal_pkg::data_t             clip_w,
	output vtal_pkg::data_t             tex_u_out,
	output vtal_pkg::data_t             tex_v_out,
	output logic [vtal_pkg::INT_W-1:0]  intensity
);
	import vtal_pkg::*;

	cfg_t  cfg;
	logic  valid_s4;
	pass_t pass_s4, pass_s16;
	data_t ny_s4, nz_s4;

	assign busy = 1'b0;

	vtal_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	vtal_geom #(
		.COEF_FRAC_BITS (COEF_FRAC_BITS),
		.DATA_FRAC_BITS (DATA_FRAC_BITS)
	) u_geom (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_in (start && !busy),
		.pos_x    (pos_x),
		.pos_y    (pos_y),
		.pos_z    (pos_z),
		.inst_x   (inst_x),
		.inst_y   (inst_y),
		.inst_z   (inst_z),
		.norm_x   (norm_x),
		.norm_y   (norm_y),
		.norm_z   (norm_z),
		.tex_u_in (tex_u_in),
		.tex_v_in (tex_v_in),
		.cfg      (cfg),
		.valid_s4 (valid_s4),
		.pass_s4  (pass_s4),
		.ny_s4    (ny_s4),
		.nz_s4    (nz_s4)
	);

	vtal_light #(
		.DATA_FRAC_BITS (DATA_FRAC_BITS)
	) u_light (
		.clk           (clk),
		.arst_n        (arst_n),
		.valid_in      (valid_s4),
		.pass_in       (pass_s4),
		.ny            (ny_s4),
		.nz            (nz_s4),
		.cfg           (cfg),
		.valid_s16     (done),
		.pass_s16      (pass_s16),
		.intensity_s16 (intensity)
	);

	assign clip_x    = pass_s16.clip[0];
	assign clip_y    = pass_s16.clip[1];
	assign clip_z    = pass_s16.clip[2];
	assign clip_w    = pass_s16.clip[3];
	assign tex_u_out = pass_s16.tex_u;
	assign tex_v_out = pass_s16.tex_v;

endmodule
